// ===== src/svlm_pkg.sv =====
`default_nettype none
package svlm_pkg;

  // field and state widths
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 27;
  localparam int COUNT_W  = 13;
  localparam int AVG_W    = 12;
  localparam int LEVEL_W  = 8;
  localparam int SHIFT_W  = 4;
  localparam int ROOT_W   = 32;

  // default buffer length cap
  localparam int MAX_PAIRS_DEF = 4096;

  // largest count the counter can hold
  localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;

  // iteration counts of the divide and root units
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int RIDX_W     = $clog2(ROOT_STEPS);

  // configuration register reset values
  localparam logic [LEVEL_W-1:0] HOLD_TIME_RST   = 8'd50;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX_RST   = 8'd79;
  localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RST = 4'd3;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIME   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_MAX   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_SHIFT = 2'd2;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_RLOAD,
    ST_ROOT,
    ST_SMOOTH,
    ST_PEAK
  } state_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] hold_time;
    logic [LEVEL_W-1:0] level_max;
    logic [SHIFT_W-1:0] scale_shift;
  } cfg_t;

  typedef struct packed {
    logic              acc;
    logic              load;
    logic              div_step;
    logic              root_load;
    logic              root_step;
    logic [RIDX_W-1:0] root_idx;
    logic              smooth;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage
`default_nettype wire

// ===== src/svlm_ctrl.sv =====
`default_nettype none
module svlm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_last_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output svlm_pkg::status_t     status_o,
  output svlm_pkg::cmd_t        cmd_o
);

  svlm_pkg::state_e state_q, state_d;
  logic [svlm_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  // state, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svlm_pkg::ST_ACC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.root_idx = cnt_q[svlm_pkg::RIDX_W-1:0];
    unique case (state_q)
      svlm_pkg::ST_ACC: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) state_d = svlm_pkg::ST_LOAD;
        end
      end
      svlm_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = svlm_pkg::ST_DIV;
      end
      svlm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == svlm_pkg::STEP_W'(svlm_pkg::DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = svlm_pkg::ST_RLOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      svlm_pkg::ST_RLOAD: begin
        cmd_o.root_load = 1'b1;
        state_d         = svlm_pkg::ST_ROOT;
      end
      svlm_pkg::ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == svlm_pkg::STEP_W'(svlm_pkg::ROOT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = svlm_pkg::ST_SMOOTH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      svlm_pkg::ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = svlm_pkg::ST_PEAK;
      end
      svlm_pkg::ST_PEAK: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = svlm_pkg::ST_ACC;
        end
      end
      default: state_d = svlm_pkg::ST_ACC;
    endcase
  end

  // output beat pending flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit)  out_valid_d = 1'b1;
  end

  assign status_o.out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== src/svlm_dp.sv =====
`default_nettype none
module svlm_dp #(
  parameter int MAX_PAIRS = svlm_pkg::MAX_PAIRS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire svlm_pkg::cmd_t                      cmd_i,
  input  wire svlm_pkg::cfg_t                      cfg_i,
  input  wire logic signed [svlm_pkg::SAMPLE_W-1:0] left_i,
  input  wire logic signed [svlm_pkg::SAMPLE_W-1:0] right_i,
  output logic [4*svlm_pkg::LEVEL_W-1:0]           out_data_o
);

  localparam int SW  = svlm_pkg::SUM_W;
  localparam int CW  = svlm_pkg::COUNT_W;
  localparam int AW  = svlm_pkg::AVG_W;
  localparam int LW  = svlm_pkg::LEVEL_W;
  localparam int RW  = svlm_pkg::ROOT_W;
  localparam int DW  = CW + 1;
  localparam int CAP_INT = (MAX_PAIRS > svlm_pkg::COUNT_LIMIT) ? svlm_pkg::COUNT_LIMIT
                                                                : MAX_PAIRS;
  localparam logic [CW-1:0] CAP     = CW'(CAP_INT);
  localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};

  // accumulator state
  logic [SW-1:0] sum_l_q, sum_l_d, sum_r_q, sum_r_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] avg_l_q, avg_l_d, avg_r_q, avg_r_d;
  logic [LW-1:0] pk_l_q, pk_l_d, tm_l_q, tm_l_d;
  logic [LW-1:0] pk_r_q, pk_r_d, tm_r_q, tm_r_d;

  // divide and root working registers
  logic [DW-1:0] dsr_q, dsr_d;
  logic [SW-1:0] dvd_l_q, dvd_l_d, dvd_r_q, dvd_r_d;
  logic [DW-1:0] rem_l_q, rem_l_d, rem_r_q, rem_r_d;
  logic [RW-1:0] x_l_q, x_l_d, x_r_q, x_r_d;
  logic [RW-1:0] rt_l_q, rt_l_d, rt_r_q, rt_r_d;
  logic [4*LW-1:0] out_q, out_d;

  // squared sample, top part
  function automatic logic [15:0] square_part(input logic [15:0] v);
    logic [15:0] mag;
    logic [31:0] sq;
    mag = v[15] ? 16'(~v + 16'd1) : v;
    sq  = mag * mag;
    return 16'(sq[31:16]);
  endfunction

  // saturating sum
  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [15:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + (SW+1)'(b);
    return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SW-1:0];
  endfunction

  // one restoring divide step, quotient bit enters at the bottom
  function automatic logic [SW+DW-1:0] div_step(input logic [SW-1:0] dvd,
                                                input logic [DW-1:0] rem,
                                                input logic [DW-1:0] dsr);
    logic [DW:0]   rs;
    logic          ge;
    logic [DW-1:0] nr;
    rs = {rem, dvd[SW-1]};
    ge = (rs >= {1'b0, dsr});
    nr = ge ? DW'(rs - {1'b0, dsr}) : rs[DW-1:0];
    return {dvd[SW-2:0], ge, nr};
  endfunction

  // one digit of the bitwise square root
  function automatic logic [2*RW-1:0] root_step(input logic [RW-1:0] x,
                                                input logic [RW-1:0] r,
                                                input logic [svlm_pkg::RIDX_W-1:0] idx);
    logic [RW-1:0] bitv;
    logic [RW:0]   t;
    logic [4:0]    sh;
    sh   = 5'(RW - 2) - {idx, 1'b0};
    bitv = RW'(1) << sh;
    t    = {1'b0, r} + {1'b0, bitv};
    if ({1'b0, x} >= t) begin
      return {RW'(x - t[RW-1:0]), RW'((r >> 1) + bitv)};
    end else begin
      return {x, RW'(r >> 1)};
    end
  endfunction

  // avg += (rms - avg) / 2, toward zero
  function automatic logic [AW-1:0] smooth(input logic [AW-1:0] avg,
                                           input logic [15:0] rms);
    logic signed [17:0] d, h, a;
    d = $signed({2'b00, rms}) - $signed({6'b0, avg});
    h = (d + $signed({17'b0, d[17]})) >>> 1;
    a = $signed({6'b0, avg}) + h;
    return a[AW-1:0];
  endfunction

  // bar length from smoothed level
  function automatic logic [LW-1:0] bar_of(input logic [AW-1:0] avg,
                                           input svlm_pkg::cfg_t cfg);
    logic [AW-1:0] v;
    v = avg >> cfg.scale_shift;
    return (v > {4'b0, cfg.level_max}) ? cfg.level_max : v[LW-1:0];
  endfunction

  logic [LW-1:0] bar_l, bar_r;
  logic [SW+DW-1:0] dv_l, dv_r;
  logic [2*RW-1:0]  rs_l, rs_r;

  assign bar_l = bar_of(avg_l_q, cfg_i);
  assign bar_r = bar_of(avg_r_q, cfg_i);
  assign dv_l  = div_step(dvd_l_q, rem_l_q, dsr_q);
  assign dv_r  = div_step(dvd_r_q, rem_r_q, dsr_q);
  assign rs_l  = root_step(x_l_q, rt_l_q, cmd_i.root_idx);
  assign rs_r  = root_step(x_r_q, rt_r_q, cmd_i.root_idx);

  // accumulate, clear, smooth and peak hold
  always_comb begin
    sum_l_d = sum_l_q;
    sum_r_d = sum_r_q;
    count_d = count_q;
    avg_l_d = avg_l_q;
    avg_r_d = avg_r_q;
    pk_l_d  = pk_l_q;
    tm_l_d  = tm_l_q;
    pk_r_d  = pk_r_q;
    tm_r_d  = tm_r_q;
    if (cmd_i.acc) begin
      sum_l_d = sat_add(sum_l_q, square_part(left_i));
      sum_r_d = sat_add(sum_r_q, square_part(right_i));
      if (count_q < CAP) count_d = count_q + 1'b1;
    end
    if (cmd_i.load) begin
      sum_l_d = '0;
      sum_r_d = '0;
      count_d = '0;
    end
    if (cmd_i.smooth) begin
      avg_l_d = smooth(avg_l_q, rt_l_q[15:0]);
      avg_r_d = smooth(avg_r_q, rt_r_q[15:0]);
    end
    if (cmd_i.emit) begin
      if (bar_l > pk_l_q) begin
        pk_l_d = bar_l;
        tm_l_d = cfg_i.hold_time;
      end else if (tm_l_q != '0) begin
        tm_l_d = tm_l_q - 1'b1;
      end else if (pk_l_q != '0) begin
        pk_l_d = pk_l_q - 1'b1;
      end
      if (bar_r > pk_r_q) begin
        pk_r_d = bar_r;
        tm_r_d = cfg_i.hold_time;
      end else if (tm_r_q != '0) begin
        tm_r_d = tm_r_q - 1'b1;
      end else if (pk_r_q != '0) begin
        pk_r_d = pk_r_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
      count_q <= '0;
      avg_l_q <= '0;
      avg_r_q <= '0;
      pk_l_q  <= '0;
      tm_l_q  <= '0;
      pk_r_q  <= '0;
      tm_r_q  <= '0;
    end else begin
      sum_l_q <= sum_l_d;
      sum_r_q <= sum_r_d;
      count_q <= count_d;
      avg_l_q <= avg_l_d;
      avg_r_q <= avg_r_d;
      pk_l_q  <= pk_l_d;
      tm_l_q  <= tm_l_d;
      pk_r_q  <= pk_r_d;
      tm_r_q  <= tm_r_d;
    end
  end

  // divide and root units, output register
  always_comb begin
    dsr_d   = dsr_q;
    dvd_l_d = dvd_l_q;
    dvd_r_d = dvd_r_q;
    rem_l_d = rem_l_q;
    rem_r_d = rem_r_q;
    x_l_d   = x_l_q;
    x_r_d   = x_r_q;
    rt_l_d  = rt_l_q;
    rt_r_d  = rt_r_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      dsr_d   = {count_q, 1'b0};
      dvd_l_d = sum_l_q;
      dvd_r_d = sum_r_q;
      rem_l_d = '0;
      rem_r_d = '0;
    end
    if (cmd_i.div_step) begin
      {dvd_l_d, rem_l_d} = dv_l;
      {dvd_r_d, rem_r_d} = dv_r;
    end
    if (cmd_i.root_load) begin
      // quotient shifted up by eight, kept to 32 bits
      x_l_d  = {dvd_l_q[RW-9:0], 8'h00};
      x_r_d  = {dvd_r_q[RW-9:0], 8'h00};
      rt_l_d = '0;
      rt_r_d = '0;
    end
    if (cmd_i.root_step) begin
      {x_l_d, rt_l_d} = rs_l;
      {x_r_d, rt_r_d} = rs_r;
    end
    if (cmd_i.emit) begin
      out_d = {pk_r_d, pk_l_d, bar_r, bar_l};
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q   <= dsr_d;
    dvd_l_q <= dvd_l_d;
    dvd_r_q <= dvd_r_d;
    rem_l_q <= rem_l_d;
    rem_r_q <= rem_r_d;
    x_l_q   <= x_l_d;
    x_r_q   <= x_r_d;
    rt_l_q  <= rt_l_d;
    rt_r_q  <= rt_r_d;
    out_q   <= out_d;
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== src/stereo_vu_level_meter.sv =====
`default_nettype none
// sequence: a last pair starts the load, 27 divide steps, root load, 16 root steps, smooth and
// peak states, and the peak state registers the result beat
// throughput: one pair per cycle while accumulating; input is held off during the divide,
// root and peak sequence of each buffer, longer while an earlier result beat waits
// reset: asynchronous active low, clears sums, count, averages, peaks, timers and
// restores the configuration registers to their defaults
module stereo_vu_level_meter #(
  parameter int MAX_PAIRS = svlm_pkg::MAX_PAIRS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // left_sample [15:0], right_sample [31:16]
  input  wire logic [2*svlm_pkg::SAMPLE_W-1:0]   s_axis_tdata,
  // last_pair
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // left_bar [7:0], right_bar [15:8], left_peak [23:16], right_peak [31:24]
  output logic [4*svlm_pkg::LEVEL_W-1:0]         m_axis_tdata,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [svlm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [svlm_pkg::LEVEL_W-1:0]      cfg_data_i
);

  svlm_pkg::cfg_t    cfg_q, cfg_d;
  svlm_pkg::cmd_t    cmd;
  svlm_pkg::status_t status;

  // configuration register writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        svlm_pkg::CFG_HOLD_TIME:   cfg_d.hold_time   = cfg_data_i;
        svlm_pkg::CFG_LEVEL_MAX:   cfg_d.level_max   = cfg_data_i;
        svlm_pkg::CFG_SCALE_SHIFT: cfg_d.scale_shift = cfg_data_i[svlm_pkg::SHIFT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time   <= svlm_pkg::HOLD_TIME_RST;
      cfg_q.level_max   <= svlm_pkg::LEVEL_MAX_RST;
      cfg_q.scale_shift <= svlm_pkg::SCALE_SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sequencer
  svlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .cmd_o       (cmd)
  );

  // arithmetic
  svlm_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .left_i     (s_axis_tdata[svlm_pkg::SAMPLE_W-1:0]),
    .right_i    (s_axis_tdata[2*svlm_pkg::SAMPLE_W-1:svlm_pkg::SAMPLE_W]),
    .out_data_o (m_axis_tdata)
  );

  assign m_axis_tvalid = status.out_valid;

endmodule
`default_nettype wire
